/* rtl/core/iss_pkg.sv */
// Shared types and codes for the indexed sequence store.
package iss_pkg;

   // Command codes carried in the cmd field of an input item.
   localparam logic [2:0] CMD_READ    = 3'd0;
   localparam logic [2:0] CMD_APPEND  = 3'd1;
   localparam logic [2:0] CMD_PREPEND = 3'd2;
   localparam logic [2:0] CMD_REMOVE  = 3'd3;
   localparam logic [2:0] CMD_SWAP    = 3'd4;
   localparam logic [2:0] CMD_WRITE   = 3'd5;

   // Status codes returned with every result item.
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Widths fixed by the item fields.
   localparam int INDEX_W = 8;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 9;

   typedef struct packed {
      logic [2:0]                cmd;
      logic [INDEX_W-1:0]        index_a;
      logic [INDEX_W-1:0]        index_b;
      logic signed [VALUE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [1:0]                status;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

   // What every cell of the chain does in a given cycle.
   typedef enum logic [2:0] {
      ACT_HOLD,
      ACT_APPEND,
      ACT_PREPEND,
      ACT_REMOVE,
      ACT_WRITE,
      ACT_SWAP_PUT,
      ACT_LOAD,
      ACT_SHIFT
   } action_type;

   // Control broadcast from the sequencer to all cells.
   typedef struct packed {
      action_type         action;
      logic [INDEX_W-1:0] index_a;
      logic [INDEX_W-1:0] index_b;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] value_b;
   } cell_ctrl_type;

endpackage

/* rtl/core/iss_cell.sv */
// One storage cell of the sequence chain: an element register and a scan register.
module iss_cell #(
   parameter int POS = 0,
   parameter int UW  = 9,
   parameter int CW  = 9
) (
   input  logic                       clock,
   input  iss_pkg::cell_ctrl_type     ctrl,
   input  logic [UW-1:0]              used,
   input  logic [iss_pkg::VALUE_W-1:0] left_slot,
   input  logic [iss_pkg::VALUE_W-1:0] right_slot,
   input  logic [iss_pkg::VALUE_W-1:0] right_scan,
   output logic [iss_pkg::VALUE_W-1:0] slot_out,
   output logic [iss_pkg::VALUE_W-1:0] scan_out
);

   localparam logic [CW-1:0] MY_POS = CW'(POS);

   logic [iss_pkg::VALUE_W-1:0] slot_ff, slot_in;
   logic [iss_pkg::VALUE_W-1:0] scan_ff, scan_in;
   logic                        hit_a, hit_b;

   assign hit_a = (MY_POS == CW'(ctrl.index_a));
   assign hit_b = (MY_POS == CW'(ctrl.index_b));

   always_comb begin
      slot_in = slot_ff;
      scan_in = scan_ff;
      case (ctrl.action)
         iss_pkg::ACT_APPEND: begin
            if (MY_POS == CW'(used)) slot_in = ctrl.value;
         end
         iss_pkg::ACT_PREPEND: begin
            slot_in = (POS == 0) ? ctrl.value : left_slot;
         end
         iss_pkg::ACT_REMOVE: begin
            if (MY_POS >= CW'(ctrl.index_a)) slot_in = right_slot;
         end
         iss_pkg::ACT_WRITE: begin
            if (hit_a) slot_in = ctrl.value;
         end
         iss_pkg::ACT_SWAP_PUT: begin
            // value carries the old element at index_a, value_b the one at index_b.
            if (hit_a) begin
               slot_in = ctrl.value_b;
            end else if (hit_b) begin
               slot_in = ctrl.value;
            end
         end
         iss_pkg::ACT_LOAD: begin
            scan_in = slot_ff;
         end
         iss_pkg::ACT_SHIFT: begin
            scan_in = right_scan;
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      scan_ff <= scan_in;
   end

   assign slot_out = slot_ff;
   assign scan_out = scan_ff;

endmodule

/* rtl/core/indexed_sequence_store_top.sv */
// Top level of the indexed sequence store: command sequencer, cell chain and result registers.
//
//   channel | ports                              | direction | payload
//   --------+------------------------------------+-----------+------------------------------
//   request | req_valid, req_ready, req_item     | in        | cmd, index_a, index_b, value_in
//   result  | rsp_valid, rsp_ready, rsp_item     | out       | read_value, status, count
//
// Append, prepend, remove, write, unused codes and every rejected command finish in the
// cycle they are accepted. A read or a swap first copies the element registers into the
// scan chain, which then moves one cell toward position zero per cycle until the last
// needed index has reached the head.
// Reset clears the element count, the sequencer and the valid flags of both result
// registers; element contents are not cleared and are only ever read below the count.
// A result register plus one skid register sit on the result side, so a command is
// taken while one finished item still waits; requests stall while the skid is full.
module indexed_sequence_store_top #(
   parameter int CAPACITY = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iss_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output iss_pkg::rsp_type rsp_item
);

   // Width of the element count, and of position compares against 8-bit indexes.
   localparam int UW = $clog2(CAPACITY + 1);
   localparam int CW = (UW > iss_pkg::INDEX_W) ? UW : iss_pkg::INDEX_W;
   localparam int VW = iss_pkg::VALUE_W;
   localparam int IW = iss_pkg::INDEX_W;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type              state_ff, state_in;
   logic [UW-1:0]          used_ff, used_in;
   logic [IW-1:0]          cnt_ff, cnt_in;
   logic [IW-1:0]          ia_ff, ia_in;
   logic [IW-1:0]          ib_ff, ib_in;
   logic [IW-1:0]          last_ff, last_in;
   logic                   swap_ff, swap_in;
   logic [VW-1:0]          a_ff, a_in;
   logic [VW-1:0]          b_ff, b_in;
   logic                   rsp_valid_ff;
   iss_pkg::rsp_type       rsp_ff;
   logic                   skid_valid_ff;
   iss_pkg::rsp_type       skid_ff;

   logic                   accept;
   logic                   ia_ok, ib_ok, full;
   logic                   comp_valid;
   logic [1:0]             comp_status;
   logic [VW-1:0]          comp_read;
   iss_pkg::rsp_type       comp;
   iss_pkg::cell_ctrl_type ctrl;
   logic [VW-1:0]          head, a_now, b_now;
   logic                   rsp_free;

   logic [VW-1:0]          slot_q [CAPACITY];
   logic [VW-1:0]          scan_q [CAPACITY];

   // The chain of cells. Neighbors hand elements along for prepend and remove,
   // and the scan registers move toward position zero during a read or swap.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VW-1:0] left_slot, right_slot, right_scan;
      if (g == 0) begin : g_first
         assign left_slot = '0;
      end else begin : g_mid
         assign left_slot = slot_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_slot = slot_q[g];
         assign right_scan = scan_q[g];
      end else begin : g_inner
         assign right_slot = slot_q[g+1];
         assign right_scan = scan_q[g+1];
      end
      iss_cell #(
         .POS (g),
         .UW  (UW),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .used       (used_ff),
         .left_slot  (left_slot),
         .right_slot (right_slot),
         .right_scan (right_scan),
         .slot_out   (slot_q[g]),
         .scan_out   (scan_q[g])
      );
   end

   assign req_ready = (state_ff == ST_IDLE) && !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   assign ia_ok = CW'(req_item.index_a) < CW'(used_ff);
   assign ib_ok = CW'(req_item.index_b) < CW'(used_ff);
   assign full  = (used_ff == UW'(CAPACITY));

   // The head of the scan chain holds the element at position cnt_ff.
   assign head  = scan_q[0];
   assign a_now = (cnt_ff == ia_ff) ? head : a_ff;
   assign b_now = (cnt_ff == ib_ff) ? head : b_ff;

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      cnt_in      = cnt_ff;
      ia_in       = ia_ff;
      ib_in       = ib_ff;
      last_in     = last_ff;
      swap_in     = swap_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      comp_valid  = 1'b0;
      comp_status = iss_pkg::STATUS_DONE;
      comp_read   = '0;

      ctrl.action  = iss_pkg::ACT_HOLD;
      ctrl.index_a = req_item.index_a;
      ctrl.index_b = req_item.index_b;
      ctrl.value   = req_item.value_in;
      ctrl.value_b = req_item.value_in;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               comp_valid = 1'b1;
               unique case (req_item.cmd)
                  iss_pkg::CMD_READ: begin
                     if (ia_ok) begin
                        comp_valid  = 1'b0;
                        ctrl.action = iss_pkg::ACT_LOAD;
                        state_in    = ST_SCAN;
                        cnt_in      = '0;
                        ia_in       = req_item.index_a;
                        ib_in       = req_item.index_a;
                        last_in     = req_item.index_a;
                        swap_in     = 1'b0;
                     end else begin
                        comp_status = iss_pkg::STATUS_RANGE;
                     end
                  end
                  iss_pkg::CMD_APPEND: begin
                     if (full) begin
                        comp_status = iss_pkg::STATUS_FULL;
                     end else begin
                        ctrl.action = iss_pkg::ACT_APPEND;
                        used_in     = used_ff + 1'b1;
                     end
                  end
                  iss_pkg::CMD_PREPEND: begin
                     if (full) begin
                        comp_status = iss_pkg::STATUS_FULL;
                     end else begin
                        ctrl.action = iss_pkg::ACT_PREPEND;
                        used_in     = used_ff + 1'b1;
                     end
                  end
                  iss_pkg::CMD_REMOVE: begin
                     if (ia_ok) begin
                        ctrl.action = iss_pkg::ACT_REMOVE;
                        used_in     = used_ff - 1'b1;
                     end else begin
                        comp_status = iss_pkg::STATUS_RANGE;
                     end
                  end
                  iss_pkg::CMD_SWAP: begin
                     if (ia_ok && ib_ok) begin
                        comp_valid  = 1'b0;
                        ctrl.action = iss_pkg::ACT_LOAD;
                        state_in    = ST_SCAN;
                        cnt_in      = '0;
                        ia_in       = req_item.index_a;
                        ib_in       = req_item.index_b;
                        last_in     = (req_item.index_a > req_item.index_b) ?
                                      req_item.index_a : req_item.index_b;
                        swap_in     = 1'b1;
                     end else begin
                        comp_status = iss_pkg::STATUS_RANGE;
                     end
                  end
                  iss_pkg::CMD_WRITE: begin
                     if (ia_ok) begin
                        ctrl.action = iss_pkg::ACT_WRITE;
                     end else begin
                        comp_status = iss_pkg::STATUS_RANGE;
                     end
                  end
                  default: begin
                     comp_status = iss_pkg::STATUS_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            a_in = a_now;
            b_in = b_now;
            if (cnt_ff == last_ff) begin
               comp_valid = 1'b1;
               state_in   = ST_IDLE;
               if (swap_ff) begin
                  ctrl.action  = iss_pkg::ACT_SWAP_PUT;
                  ctrl.index_a = ia_ff;
                  ctrl.index_b = ib_ff;
                  ctrl.value   = a_now;
                  ctrl.value_b = b_now;
               end else begin
                  comp_read = a_now;
               end
            end else begin
               ctrl.action = iss_pkg::ACT_SHIFT;
               cnt_in      = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      comp.read_value = comp_read;
      comp.status     = comp_status;
      comp.count      = iss_pkg::COUNT_W'(used_in);
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         cnt_ff   <= cnt_in;
         // A finished item goes to the result register when it is free, and to
         // the skid otherwise. No item finishes while the skid is occupied.
         if (rsp_free) begin
            if (skid_valid_ff) begin
               rsp_ff        <= skid_ff;
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else if (comp_valid) begin
               rsp_ff       <= comp;
               rsp_valid_ff <= 1'b1;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end else if (comp_valid) begin
            skid_ff       <= comp;
            skid_valid_ff <= 1'b1;
         end
      end
      ia_ff   <= ia_in;
      ib_ff   <= ib_in;
      last_ff <= last_in;
      swap_ff <= swap_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The element count never passes the capacity.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(CAPACITY))
      else $error("element count above capacity");

   // The scan counter never runs past the last index it has to reach.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= last_ff))
      else $error("scan counter overran its target");

   // A command other than a read or a swap leaves the result register valid in the next cycle.
   a_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.cmd != iss_pkg::CMD_READ && req_item.cmd != iss_pkg::CMD_SWAP)
      |=> rsp_valid_ff)
      else $error("single-cycle command produced no result");

   // The skid only fills behind an occupied result register.
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds an item while the result register is empty");

endmodule

/* tb/sv/iss_scoreboard_pkg.sv */
// Scoreboard class that mirrors the indexed sequence store and checks its result items.
package iss_scoreboard_pkg;

   class sequence_shadow #(int DEPTH = 256);
      logic signed [iss_pkg::VALUE_W-1:0] elements [DEPTH];
      int                                 held;
      iss_pkg::rsp_type                   pending_results [$];
      int unsigned                        mismatches;

      function new();
         held = 0;
         mismatches = 0;
      endfunction

      // Applies one accepted command to the mirror and queues the result it must produce.
      function void note_request(iss_pkg::req_type r);
         iss_pkg::rsp_type                   want;
         logic signed [iss_pkg::VALUE_W-1:0] swap_tmp;
         int                                 ia;
         int                                 ib;
         ia = int'(r.index_a);
         ib = int'(r.index_b);
         want.read_value = '0;
         want.status = iss_pkg::STATUS_DONE;
         case (r.cmd)
            iss_pkg::CMD_READ: begin
               if (ia < held) want.read_value = elements[ia];
               else want.status = iss_pkg::STATUS_RANGE;
            end
            iss_pkg::CMD_APPEND: begin
               if (held >= DEPTH) begin
                  want.status = iss_pkg::STATUS_FULL;
               end else begin
                  elements[held] = r.value_in;
                  held++;
               end
            end
            iss_pkg::CMD_PREPEND: begin
               if (held >= DEPTH) begin
                  want.status = iss_pkg::STATUS_FULL;
               end else begin
                  for (int i = held; i > 0; i--) elements[i] = elements[i-1];
                  elements[0] = r.value_in;
                  held++;
               end
            end
            iss_pkg::CMD_REMOVE: begin
               if (ia < held) begin
                  for (int i = ia; i + 1 < held; i++) elements[i] = elements[i+1];
                  held--;
               end else begin
                  want.status = iss_pkg::STATUS_RANGE;
               end
            end
            iss_pkg::CMD_SWAP: begin
               if (ia < held && ib < held) begin
                  swap_tmp = elements[ia];
                  elements[ia] = elements[ib];
                  elements[ib] = swap_tmp;
               end else begin
                  want.status = iss_pkg::STATUS_RANGE;
               end
            end
            iss_pkg::CMD_WRITE: begin
               if (ia < held) elements[ia] = r.value_in;
               else want.status = iss_pkg::STATUS_RANGE;
            end
            default: begin
            end
         endcase
         want.count = iss_pkg::COUNT_W'(held);
         pending_results.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      // Compares one accepted result item against the oldest queued one.
      task check_result(iss_pkg::rsp_type got);
         iss_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing queued: value %0d status %0d count %0d",
                                      got.read_value, got.status, got.count));
            return;
         end
         want = pending_results.pop_front();
         if (got.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %0d, wanted %0d", got.read_value,
                                      want.read_value));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
         if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, wanted %0d", got.count, want.count));
      endtask

      function int pending();
         return pending_results.size();
      endfunction
   endclass

endpackage

/* tb/sv/tb_indexed_sequence_store_top.sv */
// Testbench for the indexed sequence store: directed and random commands against a mirror.
module tb_indexed_sequence_store_top;

   localparam int CAPACITY     = 256;
   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = CAPACITY + 16;
   localparam int HOLD_CYCLES  = 300;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   iss_pkg::req_type req_item;
   logic             rsp_valid;
   logic             rsp_ready;
   iss_pkg::rsp_type rsp_item;

   iss_scoreboard_pkg::sequence_shadow #(CAPACITY) shadow = new();

   // While set, neither side inserts random idle cycles.
   bit          steady;
   int unsigned results_seen;

   indexed_sequence_store_top #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop far beyond the slowest correct run (every item a worst-case scan plus stalls).
   initial begin
      #20_000_000;
      $display("tb_indexed_sequence_store_top failed");
      $finish;
   end

   function automatic iss_pkg::req_type build_item(logic [2:0] cmd, logic [7:0] ia,
                                                   logic [7:0] ib, logic [31:0] v);
      iss_pkg::req_type r;
      r.cmd = cmd;
      r.index_a = ia;
      r.index_b = ib;
      r.value_in = v;
      return r;
   endfunction

   // Offers one item starting at a falling edge and holds it until the block takes it.
   // The mirror is updated at the accepting edge, so the next item sees current contents.
   task automatic offer(input iss_pkg::req_type it);
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (!req_ready);
      shadow.note_request(it);
      @(negedge clock);
   endtask

   // Drops valid about a quarter of the time. The wait after the drop runs to a falling edge,
   // so valid is never lowered and raised within one time step.
   task automatic sender_gap();
      if (!steady && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
   endtask

   // Mostly an index inside the sequence, sometimes the first index past its end, sometimes
   // anything at all, so both the in-range and out-of-range paths stay busy.
   function automatic logic [7:0] pick_index();
      int n;
      int unsigned r;
      n = shadow.held;
      r = $urandom_range(0, 99);
      if (n > 0 && r < 80) return 8'($urandom_range(0, n - 1));
      if (r < 90 && n < CAPACITY) return 8'(n);
      return 8'($urandom_range(0, 255));
   endfunction

   // Builds one random command. While growing, inserts dominate until the store is full;
   // while shrinking, removals dominate until it is empty. A few items are pure noise.
   function automatic iss_pkg::req_type random_item(bit grow);
      iss_pkg::req_type r;
      int unsigned      pick;
      r.value_in = $urandom;
      r.index_a = pick_index();
      r.index_b = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 8) begin
         r.cmd = 3'($urandom_range(0, 7));
         r.index_a = 8'($urandom_range(0, 255));
         return r;
      end
      if (grow) begin
         if (pick < 40)      r.cmd = iss_pkg::CMD_APPEND;
         else if (pick < 75) r.cmd = iss_pkg::CMD_PREPEND;
         else if (pick < 83) r.cmd = iss_pkg::CMD_READ;
         else if (pick < 88) r.cmd = iss_pkg::CMD_SWAP;
         else if (pick < 93) r.cmd = iss_pkg::CMD_WRITE;
         else if (pick < 96) r.cmd = iss_pkg::CMD_REMOVE;
         else                r.cmd = 3'($urandom_range(6, 7));
      end else begin
         if (pick < 60)      r.cmd = iss_pkg::CMD_REMOVE;
         else if (pick < 63) r.cmd = iss_pkg::CMD_APPEND;
         else if (pick < 66) r.cmd = iss_pkg::CMD_PREPEND;
         else if (pick < 78) r.cmd = iss_pkg::CMD_READ;
         else if (pick < 86) r.cmd = iss_pkg::CMD_SWAP;
         else if (pick < 94) r.cmd = iss_pkg::CMD_WRITE;
         else                r.cmd = 3'($urandom_range(6, 7));
      end
      // Swaps with the neighbor are common in real use, so favor them.
      if (r.cmd == iss_pkg::CMD_SWAP) begin
         if ($urandom_range(0, 99) < 30) r.index_b = r.index_a + 8'd1;
         else r.index_b = pick_index();
      end
      return r;
   endfunction

   // Result side: random back-pressure, one long hold-off, and sampling at the rising edge.
   initial begin
      int unsigned hold_left;
      bit          held_once;
      rsp_ready = 1'b0;
      hold_left = 0;
      held_once = 1'b0;
      results_seen = 0;
      forever begin
         @(negedge clock);
         // Once the run is well under way, refuse results long enough that the result and
         // skid registers fill and the request side has to stall.
         if (!held_once && results_seen >= 500) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 25);
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            shadow.check_result(rsp_item);
            results_seen++;
         end
      end
   end

   // Request side: reset, directed commands, then random grow and shrink passes.
   initial begin
      iss_pkg::req_type directed [$];
      bit               grow;
      int               linger;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      steady = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Index commands on an empty store are out of range, and unused codes are ignored.
      directed.push_back(build_item(iss_pkg::CMD_READ,    8'd0,   8'd0,   32'd0));
      directed.push_back(build_item(iss_pkg::CMD_REMOVE,  8'd0,   8'd255, 32'd0));
      directed.push_back(build_item(iss_pkg::CMD_SWAP,    8'd0,   8'd0,   32'd0));
      directed.push_back(build_item(iss_pkg::CMD_WRITE,   8'd0,   8'd0,   32'hFFFF_FFFF));
      directed.push_back(build_item(3'd6,                 8'd255, 8'd255, 32'hFFFF_FFFF));
      // Removing the sole element empties the store again.
      directed.push_back(build_item(iss_pkg::CMD_APPEND,  8'd0,   8'd0,   32'h7FFF_FFFF));
      directed.push_back(build_item(iss_pkg::CMD_REMOVE,  8'd0,   8'd0,   32'd0));
      // Build the sequence 0, max, min, -1 from both ends.
      directed.push_back(build_item(iss_pkg::CMD_APPEND,  8'd0,   8'd0,   32'h8000_0000));
      directed.push_back(build_item(iss_pkg::CMD_PREPEND, 8'd255, 8'd0,   32'h7FFF_FFFF));
      directed.push_back(build_item(iss_pkg::CMD_APPEND,  8'd0,   8'd255, 32'hFFFF_FFFF));
      directed.push_back(build_item(iss_pkg::CMD_PREPEND, 8'd0,   8'd0,   32'd0));
      // Reads at both ends, just past the end, and at the top of the index range.
      directed.push_back(build_item(iss_pkg::CMD_READ,    8'd0,   8'd0,   32'd0));
      directed.push_back(build_item(iss_pkg::CMD_READ,    8'd3,   8'd0,   32'd0));
      directed.push_back(build_item(iss_pkg::CMD_READ,    8'd4,   8'd0,   32'd0));
      directed.push_back(build_item(iss_pkg::CMD_READ,    8'd255, 8'd0,   32'd0));
      // Swap of the ends, swap of an element with itself, and a swap with one bad index.
      directed.push_back(build_item(iss_pkg::CMD_SWAP,    8'd0,   8'd3,   32'd0));
      directed.push_back(build_item(iss_pkg::CMD_SWAP,    8'd2,   8'd2,   32'd0));
      directed.push_back(build_item(iss_pkg::CMD_SWAP,    8'd1,   8'd255, 32'd0));
      directed.push_back(build_item(iss_pkg::CMD_WRITE,   8'd1,   8'd0,   32'h5A5A_5A5A));
      directed.push_back(build_item(iss_pkg::CMD_WRITE,   8'd200, 8'd0,   32'hA5A5_A5A5));
      directed.push_back(build_item(3'd7,                 8'd255, 8'd255, 32'h1234_5678));
      // Pop the tail, then take the head, then read what moved into position one.
      directed.push_back(build_item(iss_pkg::CMD_REMOVE,  8'd3,   8'd0,   32'd0));
      directed.push_back(build_item(iss_pkg::CMD_REMOVE,  8'd0,   8'd0,   32'd0));
      directed.push_back(build_item(iss_pkg::CMD_READ,    8'd1,   8'd0,   32'd0));
      foreach (directed[i]) begin
         sender_gap();
         offer(directed[i]);
      end

      grow = 1'b1;
      linger = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // One stretch with no idling on either side.
         steady = (n >= 200 && n < 350);
         // Once, stop offering until every queued result has come back.
         if (n == 450) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (shadow.pending() != 0);
         end
         // Stay at the full or empty boundary for a few items before turning around,
         // so inserts into a full store and commands on an empty one both happen.
         if (grow && shadow.held == CAPACITY) linger++;
         if (!grow && shadow.held == 0) linger++;
         if (linger > 5) begin
            grow = !grow;
            linger = 0;
         end
         sender_gap();
         offer(random_item(grow));
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      // Wait for the last results, then give any stray extra result time to show up.
      while (shadow.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("tb_indexed_sequence_store_top passed");
      end else begin
         $display("tb_indexed_sequence_store_top failed");
      end
      $finish;
   end

endmodule
